### hdl/smes_pkg.sv
// ----------------------------------------------------------------------------
// smes_pkg: shared types and constants of the sparse matrix entry store
// Holds the table size, key and field widths, request and status codes and
// the configuration register indexes.
package smes_pkg;

	localparam int MaxEntries = 256;
	localparam int CoordBits  = 10;
	localparam int AddrBits   = $clog2(MaxEntries);
	localparam int CountBits  = AddrBits + 1;
	localparam int KeyBits    = 2 * CoordBits;
	localparam int ValBits    = 32;
	localparam int RegBits    = 11;
	localparam int RankBits   = 8;

	// Request kinds.
	localparam logic [1:0] MODE_SET  = 2'd0;
	localparam logic [1:0] MODE_ADD  = 2'd1;
	localparam logic [1:0] MODE_GET  = 2'd2;
	localparam logic [1:0] MODE_RANK = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANK  = 2'd3;

	// Configuration register indexes.
	localparam logic [0:0] CFG_ROWS = 1'd0;
	localparam logic [0:0] CFG_COLS = 1'd1;

endpackage

### hdl/sparse_matrix_entry_store.sv
// ----------------------------------------------------------------------------
// sparse_matrix_entry_store: sorted coordinate list sparse matrix store
// Keeps up to 256 (row, col, value) entries in row-major order in one RAM.
// ----------------------------------------------------------------------------
// One request at a time. A read by rank reads its entry straight from the RAM,
// and a request out of range or with a rank past the end is answered without
// a scan. Set, add and get scan the table from its start, one RAM read per
// cycle, up to the sorted position p of the key; an insert then shifts the
// entries from p upward up one place, from the top down, with a read and then
// a write per moved entry, since the RAM has a single port. The result waits
// in an output register and the input is stalled until it is taken.
module sparse_matrix_entry_store
	import smes_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [RegBits-1:0]  cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [9:0]          row,
	input  logic [9:0]          col,
	input  logic signed [31:0]  value,
	input  logic [7:0]          rank,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  result_value,
	output logic [9:0]          result_row,
	output logic [9:0]          result_col,
	output logic [1:0]          status,
	output logic [8:0]          entry_count
);

	localparam int EntBits = KeyBits + ValBits;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_WAIT  = 7'b0000100,
		S_SRD   = 7'b0001000,
		S_SWR   = 7'b0010000,
		S_PUT   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [RegBits-1:0]   rows_q, cols_q;
	logic [CountBits-1:0] count_q;
	logic [1:0]           mode_q;
	logic [KeyBits-1:0]   key_q;
	logic [ValBits-1:0]   val_q;
	logic [CountBits-1:0] idx_q;
	logic [AddrBits-1:0]  addr;
	logic                 we;
	logic [EntBits-1:0]   wdata, rdata, hold_q;
	logic                 rd_pend_q;

	smes_ram #(.Width(EntBits), .Depth(MaxEntries)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic [KeyBits-1:0] rkey;
	logic [ValBits-1:0] rval;
	logic               in_range;
	assign rkey = rdata[EntBits-1:ValBits];
	assign rval = rdata[ValBits-1:0];
	assign in_range = ({1'b0, row} < rows_q) && ({1'b0, col} < cols_q);

	assign in_stall  = (state_q != S_IDLE);

	// RAM port control. While idle the rank is presented so that a read by
	// rank has its entry ready in the cycle after acceptance.
	always_comb begin
		we    = 1'b0;
		addr  = idx_q[AddrBits-1:0];
		wdata = hold_q;
		unique case (state_q)
			S_IDLE:  addr = rank[AddrBits-1:0];
			S_SRD:   addr = idx_q[AddrBits-1:0] - AddrBits'(1);
			S_SWR:   begin we = 1'b1; wdata = rdata; end
			S_PUT:   begin we = 1'b1; wdata = {key_q, val_q}; end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rows_q    <= RegBits'(1024);
			cols_q    <= RegBits'(1024);
			count_q   <= '0;
			out_valid <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ROWS) rows_q <= cfg_data;
				else cols_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= mode;
						key_q  <= {row, col};
						val_q  <= value;
						result_row <= '0;
						result_col <= '0;
						result_value <= '0;
						status <= ST_OK;
						if (mode == MODE_RANK) begin
							if ({1'b0, rank} < count_q) begin
								idx_q   <= CountBits'(rank);
								state_q <= S_WAIT;
							end else begin
								status <= ST_RANK;
								entry_count <= count_q;
								state_q <= S_OUT;
								out_valid <= 1'b1;
							end
						end else if (!in_range) begin
							status <= ST_RANGE;
							entry_count <= count_q;
							state_q <= S_OUT;
							out_valid <= 1'b1;
						end else begin
							idx_q     <= '0;
							rd_pend_q <= 1'b0;
							state_q   <= S_SCAN;
						end
					end
				end
				S_WAIT: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
					entry_count <= count_q;
					result_value <= rval;
					result_row <= rkey[KeyBits-1:CoordBits];
					result_col <= rkey[CoordBits-1:0];
				end
				S_SCAN: begin
					// rdata holds entry idx_q-1 when rd_pend_q is set.
					if (rd_pend_q && rkey >= key_q) begin
						rd_pend_q <= 1'b0;
						if (rkey == key_q) begin
							idx_q <= idx_q - CountBits'(1);
							if (mode_q == MODE_GET) begin
								result_value <= rval;
								entry_count <= count_q;
								state_q <= S_OUT;
								out_valid <= 1'b1;
							end else begin
								val_q <= (mode_q == MODE_ADD) ? rval + val_q : val_q;
								state_q <= S_PUT;
							end
						end else begin
							if (mode_q == MODE_GET) begin
								entry_count <= count_q;
								state_q <= S_OUT;
								out_valid <= 1'b1;
							end else if (count_q == CountBits'(MaxEntries)) begin
								status <= ST_FULL;
								entry_count <= count_q;
								state_q <= S_OUT;
								out_valid <= 1'b1;
							end else begin
								idx_q <= count_q;
								hold_q <= EntBits'(idx_q - CountBits'(1));
								state_q <= (count_q == idx_q - CountBits'(1))
									? S_PUT : S_SRD;
								count_q <= count_q + CountBits'(1);
							end
						end
					end else if (idx_q == count_q) begin
						// Past the end: the key is absent, insert at the end.
						if (mode_q == MODE_GET) begin
							entry_count <= count_q;
							state_q <= S_OUT;
							out_valid <= 1'b1;
						end else if (count_q == CountBits'(MaxEntries)) begin
							status <= ST_FULL;
							entry_count <= count_q;
							state_q <= S_OUT;
							out_valid <= 1'b1;
						end else begin
							count_q <= count_q + CountBits'(1);
							state_q <= S_PUT;
						end
					end else begin
						idx_q <= idx_q + CountBits'(1);
						rd_pend_q <= 1'b1;
					end
				end
				S_SRD: begin
					state_q <= S_SWR;
				end
				S_SWR: begin
					// Entry idx_q-1 moved to idx_q.
					idx_q <= idx_q - CountBits'(1);
					if (idx_q - CountBits'(1) == hold_q[CountBits-1:0]) state_q <= S_PUT;
					else state_q <= S_SRD;
				end
				S_PUT: begin
					result_value <= val_q;
					entry_count <= count_q;
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountBits'(MaxEntries)) else $error("entry count overflow");
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid == (state_q == S_OUT)) else $error("out_valid out of step");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == $past(count_q) + CountBits'(1))
		else $error("count changed by more than one");
	a_put_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUT |=> out_valid && status == ST_OK)
		else $error("write finished without ok status");
`endif

endmodule

### hdl/smes_ram.sv
// ----------------------------------------------------------------------------
// smes_ram: generic single-port synchronous RAM
// One read, or one write with a read of the old contents, per cycle; read data is registered.
// ----------------------------------------------------------------------------
module smes_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// Read before write: a write cycle returns the old contents, registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the sparse matrix entry store
// Drives set, add, get and read-by-rank transactions with random gaps and
// stalls, predicts every result with a sorted table of its own and compares
// the results field by field. It also fills the table to capacity and
// sweeps the row and column limits.
// ----------------------------------------------------------------------------
module tb;
	import smes_pkg::*;

	typedef struct {
		logic [1:0]  mode;
		logic [9:0]  row;
		logic [9:0]  col;
		logic [31:0] value;
		logic [7:0]  rank;
	} request_t;

	typedef struct {
		logic [31:0] value;
		logic [9:0]  row;
		logic [9:0]  col;
		logic [1:0]  status;
		logic [8:0]  count;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_ROWS;
	logic [RegBits-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = MODE_SET;
	logic [9:0] row = '0;
	logic [9:0] col = '0;
	logic signed [31:0] value = '0;
	logic [7:0] rank = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] result_value;
	logic [9:0] result_row;
	logic [9:0] result_col;
	logic [1:0] status;
	logic [8:0] entry_count;

	sparse_matrix_entry_store u_dut (.*);

	always #4 clk = ~clk;

	// Shadow copy of the table and the limits.
	logic [KeyBits-1:0] shadow_keys [MaxEntries];
	logic [31:0]        shadow_vals [MaxEntries];
	int                 shadow_count;
	int                 row_limit;
	int                 col_limit;

	request_t pending_requests[$];
	answer_t  expected_answers[$];
	int mismatches = 0;
	int answers_seen = 0;
	int full_hits = 0;
	longint cycles = 0;
	bit hold_receiver = 1'b0;
	bit in_taken = 1'b0;

	// Compute the answer to one request and update the shadow table.
	function automatic answer_t apply_request(request_t r);
		answer_t a;
		int p;
		logic [KeyBits-1:0] key;
		bit found;
		a = '{default: '0};
		a.status = ST_OK;
		if (r.mode == MODE_RANK) begin
			if (r.rank < shadow_count) begin
				a.value = shadow_vals[r.rank];
				a.row = shadow_keys[r.rank][KeyBits-1:CoordBits];
				a.col = shadow_keys[r.rank][CoordBits-1:0];
			end else begin
				a.status = ST_RANK;
			end
		end else if (r.row >= row_limit || r.col >= col_limit) begin
			a.status = ST_RANGE;
		end else begin
			key = {r.row, r.col};
			p = 0;
			while (p < shadow_count && shadow_keys[p] < key)
				p++;
			found = p < shadow_count && shadow_keys[p] == key;
			if (r.mode == MODE_GET) begin
				a.value = found ? shadow_vals[p] : '0;
			end else if (found) begin
				shadow_vals[p] = (r.mode == MODE_ADD) ? shadow_vals[p] + r.value : r.value;
				a.value = shadow_vals[p];
			end else if (shadow_count >= MaxEntries) begin
				a.status = ST_FULL;
			end else begin
				for (int i = shadow_count; i > p; i--) begin
					shadow_keys[i] = shadow_keys[i-1];
					shadow_vals[i] = shadow_vals[i-1];
				end
				shadow_keys[p] = key;
				shadow_vals[p] = r.value;
				shadow_count++;
				a.value = r.value;
			end
		end
		a.count = shadow_count[8:0];
		return a;
	endfunction

	function automatic request_t make_request(logic [1:0] m, int rw, int cl, logic [31:0] v,
			int rk);
		request_t r;
		r.mode = m;
		r.row = rw[9:0];
		r.col = cl[9:0];
		r.value = v;
		r.rank = rk[7:0];
		return r;
	endfunction

	// Random request: mostly in-range coordinates from a small pool so entries repeat.
	function automatic request_t random_request();
		int rw;
		int cl;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			rw = $urandom_range(0, 15) * (row_limit > 16 ? row_limit / 16 : 1);
			cl = $urandom_range(0, 15) * (col_limit > 16 ? col_limit / 16 : 1);
			if (rw >= 1024) rw = 1023;
			if (cl >= 1024) cl = 1023;
		end else begin
			rw = $urandom_range(0, 1023);
			cl = $urandom_range(0, 1023);
		end
		return make_request(2'($urandom_range(0, 3)), rw, cl, $urandom,
			$urandom_range(0, 9) < 8 ? $urandom_range(0, shadow_count + 2) :
			$urandom_range(0, 255));
	endfunction

	// Driver: offers queued requests with random gaps; a request stays on the
	// port until the monitor has seen it accepted.
	always @(negedge clk) begin
		cycles++;
		if (in_valid && in_taken)
			void'(pending_requests.pop_front());
		if (!in_valid || in_taken) begin
			if (pending_requests.size() > 0 && ($urandom_range(0, 3) != 0 ||
					$urandom_range(0, 1) == 0)) begin
				in_valid <= 1'b1;
				mode <= pending_requests[0].mode;
				row <= pending_requests[0].row;
				col <= pending_requests[0].col;
				value <= pending_requests[0].value;
				rank <= pending_requests[0].rank;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: usually short, occasionally long, or held by the test.
	int stall_left = 0;
	always @(negedge clk) begin
		if (hold_receiver) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			case ($urandom_range(0, 19))
				0: begin
					stall_left = $urandom_range(20, 80);
					out_stall <= 1'b1;
				end
				1, 2, 3: out_stall <= 1'b1;
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// Monitor: predicts at acceptance and checks at each result.
	always @(posedge clk) begin
		answer_t exp_a;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken)
			expected_answers.push_back(apply_request(pending_requests[0]));
		if (arst_n && out_valid && !out_stall) begin
			answers_seen++;
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %0d status %0d", result_value, status);
			end else begin
				exp_a = expected_answers.pop_front();
				if (exp_a.status == ST_FULL)
					full_hits++;
				if (result_value !== exp_a.value || result_row !== exp_a.row ||
						result_col !== exp_a.col || status !== exp_a.status ||
						entry_count !== exp_a.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp v=%0d r=%0d c=%0d st=%0d n=%0d got v=%0d r=%0d c=%0d st=%0d n=%0d",
							$signed(exp_a.value), exp_a.row, exp_a.col, exp_a.status,
							exp_a.count, result_value, result_row, result_col, status,
							entry_count);
				end
			end
		end
		if (cycles > 4000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic drain();
		while (pending_requests.size() > 0 || in_valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [0:0] idx, int v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[RegBits-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ROWS) row_limit = v;
		else col_limit = v;
	endtask

	initial begin
		int limits [5] = '{1024, 1, 2047, 37, 0};
		shadow_count = 0;
		row_limit = 1024;
		col_limit = 1024;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, every mode, a get of an absent key and ranks past the end.
		pending_requests.push_back(make_request(MODE_RANK, 0, 0, 0, 0));
		pending_requests.push_back(make_request(MODE_GET, 1023, 1023, 0, 0));
		pending_requests.push_back(make_request(MODE_SET, 1023, 1023, 32'h7fffffff, 0));
		pending_requests.push_back(make_request(MODE_ADD, 1023, 1023, 1, 0));
		pending_requests.push_back(make_request(MODE_SET, 0, 0, 32'h80000000, 0));
		pending_requests.push_back(make_request(MODE_ADD, 0, 0, 32'hffffffff, 0));
		pending_requests.push_back(make_request(MODE_SET, 5, 7, 0, 0));
		pending_requests.push_back(make_request(MODE_ADD, 5, 6, 32'h5555aaaa, 0));
		pending_requests.push_back(make_request(MODE_GET, 5, 7, 0, 0));
		pending_requests.push_back(make_request(MODE_GET, 9, 9, 0, 0));
		pending_requests.push_back(make_request(MODE_RANK, 0, 0, 0, 1));
		pending_requests.push_back(make_request(MODE_RANK, 1023, 1023, 0, 3));
		pending_requests.push_back(make_request(MODE_RANK, 0, 0, 0, 4));
		pending_requests.push_back(make_request(MODE_RANK, 0, 0, 0, 255));
		drain();

		// Limits at the extremes and in between, with range violations.
		foreach (limits[i]) begin
			write_limit(CFG_ROWS, limits[i]);
			write_limit(CFG_COLS, limits[(i + 2) % 5]);
			pending_requests.push_back(make_request(MODE_SET, 0, 0, 3, 0));
			pending_requests.push_back(make_request(MODE_GET, 36, 37, 0, 0));
			pending_requests.push_back(make_request(MODE_ADD, 1023, 0, 3, 0));
			pending_requests.push_back(make_request(MODE_ADD, 0, 1023, 3, 0));
			for (int k = 0; k < 60; k++)
				pending_requests.push_back(random_request());
			drain();
		end
		write_limit(CFG_ROWS, 1024);
		write_limit(CFG_COLS, 1024);

		// Random mix, with one long receiver hold-off so the input stalls.
		for (int k = 0; k < 800; k++)
			pending_requests.push_back(random_request());
		hold_receiver = 1'b1;
		repeat (3000) @(posedge clk);
		hold_receiver = 1'b0;
		drain();

		// Fill the table to capacity, then probe full-table behavior.
		for (int k = 0; k < 300; k++)
			pending_requests.push_back(make_request(MODE_SET, k, 1023 - k, $urandom, 0));
		pending_requests.push_back(make_request(MODE_ADD, 0, 1023, 5, 0));
		pending_requests.push_back(make_request(MODE_ADD, 1000, 1000, 5, 0));
		pending_requests.push_back(make_request(MODE_RANK, 0, 0, 0, 255));
		for (int k = 0; k < 500; k++)
			pending_requests.push_back(random_request());
		drain();

		$display("%0d results checked, %0d table-full rejections, final table size %0d",
			answers_seen, full_hits, shadow_count);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
